// ===== src/assert_macros.svh =====
// assertion helpers used by predecessor_lookup_table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/plt_pkg.sv =====
// ----------------------------------------------------------------------------
// plt_pkg
// Shared sizes, beat layouts and status codes of the predecessor lookup table.
// ----------------------------------------------------------------------------
package plt_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int KEY_W      = 16;
    localparam int IDENT_W    = 31;
    localparam int ENTRY_W    = KEY_W + IDENT_W;
    localparam int S_TDATA_W  = ((KEY_W + IDENT_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((IDENT_W + KEY_W + 7) / 8) * 8;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        STATUS_ADDED = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_FOUND = 2'd2,
        STATUS_NONE  = 2'd3
    } status_t;

endpackage

// ===== src/plt_ram.sv =====
// ----------------------------------------------------------------------------
// plt_ram
// Generic single-port synchronous ram with a registered read.
// ----------------------------------------------------------------------------
module plt_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [DATA_W-1:0] wdata,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/predecessor_lookup_table.sv =====
// An add beat appends one (key, identifier) entry to a table of TABLE_DEPTH
// entries, or reports the table full; its result passes through ST_DONE to
// the output register. A query beat returns the stored entry with the greatest
// key strictly below the given limit, ties going to the larger identifier; it
// scans in ST_SCAN, then passes ST_DRAIN and ST_DONE, or goes straight to
// ST_DONE on an empty table. The table sits in one single-port memory that is
// read one entry per cycle from the first entry to the last. One item is worked
// on at a time; the next beat is taken while a finished result still waits
// on the master side. The table is empty after reset, with no clearing pass.
// ----------------------------------------------------------------------------
// predecessor_lookup_table
// Bounded key/identifier table with append and strict-predecessor query.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module predecessor_lookup_table
    import plt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // key_value, entry_ident
    input  logic [0:0]           s_tuser,   // operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // found_ident, found_key
    output logic [1:0]           m_tuser    // status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [ADDR_W-1:0]      idx_reg, idx_next;
    logic                   vld_reg, vld_next;
    op_t                    op_reg, op_next;
    status_t                status_reg, status_next;
    logic [KEY_W-1:0]       limit_reg, limit_next;
    logic                   have_reg, have_next;
    logic [KEY_W-1:0]       best_key_reg, best_key_next;
    logic [IDENT_W-1:0]     best_ident_reg, best_ident_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    status_t                m_tuser_reg, m_tuser_next;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_addr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic [ENTRY_W-1:0]     ram_rdata;

    logic [KEY_W-1:0]       s_key;
    logic [IDENT_W-1:0]     s_ident;
    op_t                    s_op;
    logic [KEY_W-1:0]       rd_key;
    logic [IDENT_W-1:0]     rd_ident;
    logic                   table_full;
    logic                   last_idx;
    logic                   cand;
    logic                   out_free;

    assign s_key    = s_tdata[KEY_W-1:0];
    assign s_ident  = s_tdata[KEY_W+IDENT_W-1:KEY_W];
    assign s_op     = op_t'(s_tuser[0]);
    assign rd_key   = ram_rdata[KEY_W-1:0];
    assign rd_ident = ram_rdata[ENTRY_W-1:KEY_W];

    assign table_full = (count_reg == CNT_W'(TABLE_DEPTH));
    assign last_idx   = ({1'b0, idx_reg} == (count_reg - 1'b1));
    assign out_free   = !m_tvalid_reg || m_tready;

    // strictly below the limit and better than the best so far
    assign cand = (rd_key < limit_reg) &&
                  (!have_reg || (rd_key > best_key_reg) ||
                   ((rd_key == best_key_reg) && (rd_ident > best_ident_reg)));

    plt_ram #(
        .DATA_W (ENTRY_W),
        .DEPTH  (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        vld_next        = vld_reg;
        op_next         = op_reg;
        status_next     = status_reg;
        limit_next      = limit_reg;
        have_next       = have_reg;
        best_key_next   = best_key_reg;
        best_ident_next = best_ident_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        ram_we          = 1'b0;
        ram_addr        = idx_reg;
        ram_wdata       = {s_ident, s_key};

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        // read data is registered, so it arrives in the cycle after its address
        if (vld_reg && cand) begin
            have_next       = 1'b1;
            best_key_next   = rd_key;
            best_ident_next = rd_ident;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next         = s_op;
                    limit_next      = s_key;
                    have_next       = 1'b0;
                    best_key_next   = '0;
                    best_ident_next = '0;
                    idx_next        = '0;
                    if (s_op == OP_ADD) begin
                        if (table_full) begin
                            status_next = STATUS_FULL;
                        end else begin
                            ram_we      = 1'b1;
                            ram_addr    = count_reg[ADDR_W-1:0];
                            count_next  = count_reg + 1'b1;
                            status_next = STATUS_ADDED;
                        end
                        state_next = ST_DONE;
                    end else if (count_reg == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                vld_next = 1'b1;
                if (last_idx) begin
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                vld_next   = 1'b0;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    if (op_reg == OP_ADD) begin
                        m_tuser_next = status_reg;
                        m_tdata_next = '0;
                    end else if (have_reg) begin
                        m_tuser_next = STATUS_FOUND;
                        m_tdata_next = M_TDATA_W'({best_key_reg, best_ident_reg});
                    end else begin
                        m_tuser_next = STATUS_NONE;
                        m_tdata_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            vld_reg      <= 1'b0;
            have_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            vld_reg      <= vld_next;
            have_reg     <= have_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg         <= op_next;
        status_reg     <= status_next;
        limit_reg      <= limit_next;
        best_key_reg   <= best_key_next;
        best_ident_reg <= best_ident_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(TABLE_DEPTH), "entry count past table depth")
    `ASSERT_IMPL(a_write_when_idle, aclk, aresetn, ram_we, (state_reg == ST_IDLE) && !table_full, "table written outside an add")
    `ASSERT_NEXT(a_write_counts, aclk, aresetn, ram_we, count_reg == $past(count_reg) + 1'b1, "add did not bump entry count")
    `ASSERT_NEXT(a_done_loads_out, aclk, aresetn, (state_reg == ST_DONE) && out_free, m_tvalid_reg && (state_reg == ST_IDLE), "finished item not moved to output")

endmodule
